### src/ssd_pkg.sv
// Shared types, constants and the exponent coefficient table of the soft symbol demapper.
`default_nettype none
package ssd_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int MAX_DIMS   = 4;
  localparam int DIM_W      = $clog2(MAX_DIMS);
  localparam int COORD_W    = 16;
  localparam int FRAC2      = 2 * (COORD_W - 4);
  localparam int ACC_W      = 2 * COORD_W + DIM_W;
  localparam int HI_W       = ACC_W - FRAC2;
  localparam int NOISE_W    = 16;
  localparam int DIST_W     = HI_W + NOISE_W + 1;
  localparam int METRIC_W   = 14;
  localparam logic [METRIC_W-1:0] METRIC_CAP = 14'd10240;
  localparam int EXP_W      = 25;
  localparam int COEF_W     = 24;
  localparam int EXP_STEPS  = 14;
  localparam int PROB_W     = 16;
  localparam int SUME_W     = EXP_W + IDX_W;
  localparam int SUMB_W     = PROB_W + IDX_W;
  localparam int QUOT_W     = PROB_W + 1;
  localparam int NUM_W      = EXP_W + PROB_W;
  localparam int DEN_W      = SUME_W;
  localparam int CNT_W      = $clog2(QUOT_W + 1);

  typedef enum logic [1:0] {
    CFG_INV_NOISE   = 2'd0,
    CFG_DIMS_USED   = 2'd1,
    CFG_POINTS_USED = 2'd2,
    CFG_CLIP_FLOOR  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_D_RD, ST_D_ACC, ST_D_SCALE,
    ST_E_RD, ST_E_INIT, ST_E_STEP, ST_E_WR,
    ST_A_RD, ST_A_START, ST_A_DIV, ST_A_WR,
    ST_P_RD, ST_P_START, ST_P_DIV, ST_P_OUT
  } state_t;

  typedef struct packed {
    logic             load_we;
    logic             capture;
    logic             pt_rd;
    logic             acc_en;
    logic             scale_en;
    logic             dist_rd;
    logic             e_init;
    logic             e_step;
    logic             e_wr;
    logic             ex_rd;
    logic             div_start_a;
    logic             a_wr;
    logic             pa_rd;
    logic             div_start_p;
    logic             out_load;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] q;
    logic [DIM_W-1:0] j;
    logic [3:0]       k;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } ctl_stat_t;

  // round(exp(-2^k/512) * 2^24)
  function automatic logic [COEF_W-1:0] exp_coef(input logic [3:0] k);
    logic [COEF_W-1:0] c;
    case (k)
      4'd0:    c = 24'd16744480;
      4'd1:    c = 24'd16711808;
      4'd2:    c = 24'd16646655;
      4'd3:    c = 24'd16517109;
      4'd4:    c = 24'd16261035;
      4'd5:    c = 24'd15760736;
      4'd6:    c = 24'd14805841;
      4'd7:    c = 24'd13066109;
      4'd8:    c = 24'd10175896;
      4'd9:    c = 24'd6171993;
      4'd10:   c = 24'd2270549;
      4'd11:   c = 24'd307285;
      4'd12:   c = 24'd5628;
      4'd13:   c = 24'd2;
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### src/ssd_ctrl.sv
// Sequencer of the demapper: walks the points through the four passes.
`default_nettype none
module ssd_ctrl
  import ssd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             op,
  input  wire logic [IDX_W-1:0] n_last,
  input  wire logic [DIM_W-1:0] d_last,
  input  wire ctl_stat_t        stat,
  output logic                  in_ready,
  output ctl_cmd_t              cmd
);

  state_t           state, state_next;
  logic [IDX_W-1:0] q, q_next;
  logic [DIM_W-1:0] j, j_next;
  logic [3:0]       k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      q     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      q     <= q_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    q_next     = q;
    j_next     = j;
    k_next     = k;
    case (state)
      ST_IDLE: begin
        if (in_valid && op) begin
          state_next = ST_D_RD;
          q_next     = '0;
        end
      end
      ST_D_RD: begin
        state_next = ST_D_ACC;
        j_next     = '0;
      end
      ST_D_ACC: begin
        if (j == d_last) state_next = ST_D_SCALE;
        else j_next = j + 1'b1;
      end
      ST_D_SCALE: begin
        if (q == n_last) begin
          state_next = ST_E_RD;
          q_next     = '0;
        end else begin
          state_next = ST_D_RD;
          q_next     = q + 1'b1;
        end
      end
      ST_E_RD:   state_next = ST_E_INIT;
      ST_E_INIT: begin
        state_next = ST_E_STEP;
        k_next     = '0;
      end
      ST_E_STEP: begin
        if (k == 4'(EXP_STEPS - 1)) state_next = ST_E_WR;
        else k_next = k + 1'b1;
      end
      ST_E_WR: begin
        if (q == n_last) begin
          state_next = ST_A_RD;
          q_next     = '0;
        end else begin
          state_next = ST_E_RD;
          q_next     = q + 1'b1;
        end
      end
      ST_A_RD:    state_next = ST_A_START;
      ST_A_START: state_next = ST_A_DIV;
      ST_A_DIV: begin
        if (!stat.div_busy) state_next = ST_A_WR;
      end
      ST_A_WR: begin
        if (q == n_last) begin
          state_next = ST_P_RD;
          q_next     = '0;
        end else begin
          state_next = ST_A_RD;
          q_next     = q + 1'b1;
        end
      end
      ST_P_RD:    state_next = ST_P_START;
      ST_P_START: state_next = ST_P_DIV;
      ST_P_DIV: begin
        if (!stat.div_busy) state_next = ST_P_OUT;
      end
      ST_P_OUT: begin
        if (stat.out_free) begin
          if (q == n_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_P_RD;
            q_next     = q + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.q     = q;
    cmd.j     = j;
    cmd.k     = k;
    cmd.first = (q == '0);
    cmd.last  = (q == n_last);
    in_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid && op;
        cmd.load_we = in_valid && !op;
      end
      ST_D_RD:    cmd.pt_rd       = 1'b1;
      ST_D_ACC:   cmd.acc_en      = 1'b1;
      ST_D_SCALE: cmd.scale_en    = 1'b1;
      ST_E_RD:    cmd.dist_rd     = 1'b1;
      ST_E_INIT:  cmd.e_init      = 1'b1;
      ST_E_STEP:  cmd.e_step      = 1'b1;
      ST_E_WR:    cmd.e_wr        = 1'b1;
      ST_A_RD:    cmd.ex_rd       = 1'b1;
      ST_A_START: cmd.div_start_a = 1'b1;
      ST_A_WR:    cmd.a_wr        = 1'b1;
      ST_P_RD:    cmd.pa_rd       = 1'b1;
      ST_P_START: cmd.div_start_p = 1'b1;
      ST_P_OUT:   cmd.out_load    = stat.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/ssd_dp.sv
// Datapath: point store, distance, exponent, divider, scratch stores and result register.
`default_nettype none
module ssd_dp
  import ssd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ctl_cmd_t                  cmd,
  input  wire logic [IDX_W-1:0]          point_index,
  input  wire logic signed [COORD_W-1:0] coord0,
  input  wire logic signed [COORD_W-1:0] coord1,
  input  wire logic signed [COORD_W-1:0] coord2,
  input  wire logic signed [COORD_W-1:0] coord3,
  input  wire logic [NOISE_W-1:0]        inv_noise,
  input  wire logic [PROB_W-1:0]         clip_floor,
  input  wire logic                      out_ready,
  output ctl_stat_t                      stat,
  output logic                           out_valid,
  output logic [IDX_W-1:0]               symbol_index,
  output logic [PROB_W-1:0]              probability,
  output logic                           last_point
);

  // stores
  logic [MAX_DIMS*COORD_W-1:0] pt_mem   [MAX_POINTS];
  logic [DIST_W-1:0]           dist_mem [MAX_POINTS];
  logic [EXP_W-1:0]            ex_mem   [MAX_POINTS];
  logic [PROB_W-1:0]           pa_mem   [MAX_POINTS];

  logic [MAX_DIMS*COORD_W-1:0] pt_q;
  logic [DIST_W-1:0]           dist_q;
  logic [EXP_W-1:0]            ex_q;
  logic [PROB_W-1:0]           pa_q;

  logic signed [COORD_W-1:0]   y [MAX_DIMS];
  logic [ACC_W-1:0]            acc;
  logic [DIST_W-1:0]           dmin;
  logic [METRIC_W-1:0]         m;
  logic [EXP_W-1:0]            e;
  logic [SUME_W-1:0]           sum_e;
  logic [SUMB_W-1:0]           sum_b;

  // divider
  logic [DEN_W-1:0]  rem;
  logic [QUOT_W-1:0] nlow;
  logic [QUOT_W-1:0] quot;
  logic [DEN_W-1:0]  den;
  logic              den_zero;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  logic signed [COORD_W:0]     diff;
  logic signed [2*COORD_W+1:0] sq;
  logic [HI_W+NOISE_W-1:0]     hi_prod;
  logic [FRAC2+NOISE_W-1:0]    lo_prod;
  logic [DIST_W-1:0]           dist_new;
  logic [DIST_W-1:0]           mdiff;
  logic [EXP_W+COEF_W-1:0]     e_prod;
  logic [EXP_W+COEF_W-1:0]     e_rnd;
  logic [NUM_W-1:0]            num_a, num_p, num_sel;
  logic [DEN_W-1:0]            den_sel;
  logic [DEN_W:0]              trial;
  logic                        qbit;
  logic [PROB_W-1:0]           quot_sat;
  logic [PROB_W-1:0]           b_val;

  assign diff = {y[cmd.j][COORD_W-1], y[cmd.j]}
              - {pt_q[cmd.j*COORD_W + COORD_W-1], pt_q[cmd.j*COORD_W +: COORD_W]};
  assign sq   = diff * diff;

  assign hi_prod  = acc[ACC_W-1:FRAC2] * inv_noise;
  assign lo_prod  = acc[FRAC2-1:0] * inv_noise;
  assign dist_new = DIST_W'(hi_prod) + DIST_W'(lo_prod[FRAC2+NOISE_W-1:FRAC2]);

  assign mdiff  = dist_q - dmin;
  assign e_prod = e * exp_coef(cmd.k);
  assign e_rnd  = e_prod + (EXP_W+COEF_W)'(1 << (COEF_W - 1));

  assign num_a   = {ex_q, PROB_W'(0)} + NUM_W'(sum_e[SUME_W-1:1]);
  assign num_p   = NUM_W'({pa_q, PROB_W'(0)}) + NUM_W'(sum_b[SUMB_W-1:1]);
  assign num_sel = cmd.div_start_a ? num_a : num_p;
  assign den_sel = cmd.div_start_a ? sum_e : DEN_W'(sum_b);

  assign trial    = {rem, nlow[QUOT_W-1]};
  assign qbit     = (trial >= {1'b0, den});
  assign quot_sat = den_zero ? '0 : (quot[QUOT_W-1] ? '1 : quot[PROB_W-1:0]);
  assign b_val    = (quot_sat < clip_floor) ? clip_floor : quot_sat;

  always_ff @(posedge clk) begin
    if (cmd.load_we) pt_mem[point_index] <= {coord3, coord2, coord1, coord0};
    if (cmd.pt_rd)   pt_q <= pt_mem[cmd.q];
    if (cmd.scale_en) dist_mem[cmd.q] <= dist_new;
    if (cmd.dist_rd)  dist_q <= dist_mem[cmd.q];
    if (cmd.e_wr)     ex_mem[cmd.q] <= e;
    if (cmd.ex_rd)    ex_q <= ex_mem[cmd.q];
    if (cmd.a_wr)     pa_mem[cmd.q] <= b_val;
    if (cmd.pa_rd)    pa_q <= pa_mem[cmd.q];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      y[0]  <= coord0;
      y[1]  <= coord1;
      y[2]  <= coord2;
      y[3]  <= coord3;
      sum_e <= '0;
      sum_b <= '0;
    end
    if (cmd.pt_rd)  acc <= '0;
    if (cmd.acc_en) acc <= acc + ACC_W'($unsigned(sq));
    if (cmd.scale_en && (cmd.first || dist_new < dmin)) dmin <= dist_new;
    if (cmd.e_init) begin
      m <= (mdiff > DIST_W'(METRIC_CAP)) ? METRIC_CAP : mdiff[METRIC_W-1:0];
      e <= EXP_W'(1 << COEF_W);
    end
    if (cmd.e_step && m[cmd.k]) e <= e_rnd[EXP_W+COEF_W-1:COEF_W];
    if (cmd.e_wr) sum_e <= sum_e + SUME_W'(e);
    if (cmd.a_wr) sum_b <= sum_b + SUMB_W'(b_val);
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.div_start_a || cmd.div_start_p) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(QUOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_a || cmd.div_start_p) begin
      rem      <= DEN_W'(num_sel[NUM_W-1:QUOT_W]);
      nlow     <= num_sel[QUOT_W-1:0];
      den      <= den_sel;
      den_zero <= (den_sel == '0);
      quot     <= '0;
    end else if (busy) begin
      rem  <= qbit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      nlow <= {nlow[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], qbit};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      symbol_index <= cmd.q;
      probability  <= quot_sat;
      last_point   <= cmd.last;
    end
  end

  assign stat.div_busy = busy;
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

### src/soft_symbol_demapper_top.sv
// Top level of the soft symbol demapper: register bank, sequencer and datapath.
`default_nettype none
// Soft symbol demapper. A load word (op 0) stores one constellation point of
// four Q4.12 coordinates. A demap word (op 1) carries a received vector; the
// block then gives one Q0.16 probability word per point in use, point 0
// first, last_point set on the final one. One word is worked on at a time:
// in_ready is high only when the sequencer is idle. A demap runs a distance
// pass, an exponent pass (14 shift-and-multiply steps) and two normalising
// passes that share one restoring divider. The last result word may still
// wait in the output register when the next input word is taken. The user
// must write registers through the cfg port only between demaps; the block
// itself does not enforce this. points_used and dims_used are clamped to
// their legal ranges.
module soft_symbol_demapper_top
  import ssd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      op,
  input  wire logic [IDX_W-1:0]          point_index,
  input  wire logic signed [COORD_W-1:0] coord0,
  input  wire logic signed [COORD_W-1:0] coord1,
  input  wire logic signed [COORD_W-1:0] coord2,
  input  wire logic signed [COORD_W-1:0] coord3,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [IDX_W-1:0]               symbol_index,
  output logic [PROB_W-1:0]              probability,
  output logic                           last_point,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [15:0]               cfg_data
);

  logic [NOISE_W-1:0] inv_noise;
  logic [2:0]         dims_used;
  logic [6:0]         points_used;
  logic [PROB_W-1:0]  clip_floor;
  logic [IDX_W-1:0]   n_last;
  logic [DIM_W-1:0]   d_last;
  ctl_cmd_t           cmd;
  ctl_stat_t          stat;

  assign cfg_ready = 1'b1;

  // register bank
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_noise   <= 16'd256;
      dims_used   <= 3'd3;
      points_used <= 7'd8;
      clip_floor  <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INV_NOISE:   inv_noise   <= cfg_data;
        CFG_DIMS_USED:   dims_used   <= cfg_data[2:0];
        CFG_POINTS_USED: points_used <= cfg_data[6:0];
        CFG_CLIP_FLOOR:  clip_floor  <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped last indexes for the sequencer
  always_comb begin
    if (points_used == 7'd0)                   n_last = '0;
    else if (points_used > 7'(MAX_POINTS))     n_last = IDX_W'(MAX_POINTS - 1);
    else                                       n_last = IDX_W'(points_used - 7'd1);
    if (dims_used == 3'd0)                     d_last = '0;
    else if (dims_used > 3'(MAX_DIMS))         d_last = DIM_W'(MAX_DIMS - 1);
    else                                       d_last = DIM_W'(dims_used - 3'd1);
  end

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .n_last   (n_last),
    .d_last   (d_last),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  ssd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .point_index  (point_index),
    .coord0       (coord0),
    .coord1       (coord1),
    .coord2       (coord2),
    .coord3       (coord3),
    .inv_noise    (inv_noise),
    .clip_floor   (clip_floor),
    .out_ready    (out_ready),
    .stat         (stat),
    .out_valid    (out_valid),
    .symbol_index (symbol_index),
    .probability  (probability),
    .last_point   (last_point)
  );

  // a demap word keeps the sequencer busy on the following cycle
  a_demap_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op |=> !in_ready)
    else $error("input taken again straight after a demap word");

  // only the final word of a demap may still wait once the block is idle
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_point |-> !in_ready)
    else $error("idle with a non-final result word pending");

  // the final word belongs to the last point in use
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> symbol_index == n_last)
    else $error("last_point on the wrong symbol");

endmodule
`default_nettype wire
